[design/ssfl_pkg.sv]
// ----------------------------------------------------------------------------
// ssfl_pkg: shared types and constants for the substring search unit
// Holds the window, result and register index definitions used by the
// compare slice, the result buffer and the top level.
// ----------------------------------------------------------------------------
package ssfl_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_TEXT    = 65536;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = MAX_PATTERN * BYTE_W;
  localparam int LEN_W     = 4;
  localparam int MODE_W    = 2;
  localparam int POS_W     = $clog2(MAX_TEXT + 1);
  localparam int INDEX_W   = 16;
  localparam int WIN_IDX_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = PAT_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE    = 2'd2;

  // search_mode bit positions
  localparam int MODE_FOLD_BIT = 0;
  localparam int MODE_LAST_BIT = 1;

  // Entry 0 is the newest byte
  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

  typedef struct packed {
    logic                found;
    logic [INDEX_W-1:0]  match_index;
    logic                too_long;
  } result_t;

endpackage

[design/ssfl_if.sv]
// ----------------------------------------------------------------------------
// ssfl_if: stream channels of the substring search unit
// Text byte channel and search result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssfl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ssfl_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_index;
  logic        too_long;

  modport source (output valid, output found, output match_index, output too_long,
                  input ready);
  modport sink   (input valid, input found, input match_index, input too_long,
                  output ready);
endinterface

[design/substring_search_first_last_unit.sv]
// ----------------------------------------------------------------------------
// substring_search_first_last_unit: streaming first/last substring search
// Searches a byte stream for a configured pattern of 1 to 8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   text   - one text byte per transfer; last_byte marks the final byte.
//   result - one transfer per text: found, match_index, too_long.
//   cfg_*  - write pattern_bytes (0), pattern_length (1), search_mode (2)
//            while no text is in flight.
// Throughput: one text byte per cycle while the skid entry is free. The window
//   compare is a single bank of eight comparators fed from the accepted byte.
// Result: the result for a text is registered into the output register when
//   its last byte transfers, or into the skid entry while an earlier one waits.
// Stall: results sit in an output register backed by one skid entry; text
//   is taken as long as the skid entry is free, so bytes keep flowing while
//   one result waits. Text ready drops only when two results are pending.
// Reset: rst clears the text state, both result entries and the
//   registers (pattern 0, length 1, mode exact/first match).
// ----------------------------------------------------------------------------
module substring_search_first_last_unit (
  input  logic                                clk,
  input  logic                                rst,
  ssfl_text_if.sink                           text,
  ssfl_result_if.source                       result,
  input  logic                                cfg_write,
  input  logic [ssfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssfl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssfl_pkg::*;

  // Configuration registers
  logic [PAT_W-1:0]  pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic [MODE_W-1:0] search_mode;

  // Per-text state
  window_t           recent_bytes;
  logic [POS_W-1:0]  byte_position;
  logic              have_match;
  logic [INDEX_W-1:0] kept_index;
  logic              overflowed;

  window_t            recent_bytes_next;
  logic [POS_W-1:0]   byte_position_next;
  logic               have_match_next;
  logic [INDEX_W-1:0] kept_index_next;
  logic               overflowed_next;

  logic [LEN_W-1:0]  len_eff;
  logic              accept;
  logic              saturated;
  logic [POS_W-1:0]  pos_plus1;
  logic [POS_W-1:0]  start_pos;
  logic              check;
  logic              match;
  logic              take;
  logic              buf_space;
  result_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= LEN_W'(1);
      search_mode    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_SEARCH_MODE:    search_mode    <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign accept    = text.valid && text.ready;
  assign text.ready = buf_space;

  assign saturated = (byte_position == POS_W'(MAX_TEXT));
  assign pos_plus1 = byte_position + POS_W'(1);
  assign start_pos = pos_plus1 - POS_W'(len_eff);
  // Hold off until a full pattern length of text has arrived; stop once saturated
  assign check     = !saturated && (pos_plus1 >= POS_W'(len_eff));

  // Shift the new byte into entry 0
  assign recent_bytes_next = {recent_bytes[MAX_PATTERN-2:0], text.text_byte};

  ssfl_compare u_compare (
    .window  (recent_bytes_next),
    .pattern (pattern_bytes),
    .len     (len_eff),
    .fold    (search_mode[MODE_FOLD_BIT]),
    .match   (match)
  );

  // Keep the first match, or every later one in last-match mode
  assign take = check && match && (search_mode[MODE_LAST_BIT] || !have_match);

  always_comb begin
    byte_position_next = saturated ? byte_position : pos_plus1;
    overflowed_next    = overflowed || saturated;
    have_match_next    = have_match || take;
    kept_index_next    = take ? start_pos[INDEX_W-1:0] : kept_index;
  end

  always_comb begin
    res.found       = have_match_next;
    res.match_index = have_match_next ? kept_index_next : '0;
    res.too_long    = overflowed_next;
  end

  // Advance on every transfer; the last byte clears the text state
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes  <= '0;
      byte_position <= '0;
      have_match    <= 1'b0;
      kept_index    <= '0;
      overflowed    <= 1'b0;
    end else if (accept) begin
      if (text.last_byte) begin
        recent_bytes  <= '0;
        byte_position <= '0;
        have_match    <= 1'b0;
        kept_index    <= '0;
        overflowed    <= 1'b0;
      end else begin
        if (!saturated) begin
          recent_bytes <= recent_bytes_next;
        end
        byte_position <= byte_position_next;
        have_match    <= have_match_next;
        kept_index    <= kept_index_next;
        overflowed    <= overflowed_next;
      end
    end
  end

  result_t out_data;

  ssfl_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && text.last_byte),
    .push_data (res),
    .space     (buf_space),
    .valid     (result.valid),
    .ready     (result.ready),
    .data      (out_data)
  );

  assign result.found       = out_data.found;
  assign result.match_index = out_data.match_index;
  assign result.too_long    = out_data.too_long;

`ifndef SYNTH
  a_overflow_at_limit: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> (byte_position == POS_W'(MAX_TEXT)))
    else $error("overflow flagged before the position saturated");

  a_position_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_W'(MAX_TEXT))
    else $error("byte position past the text limit");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && text.last_byte) |=> (byte_position == '0 && !have_match && !overflowed))
    else $error("text state not cleared after the last byte");
`endif

endmodule

[design/ssfl_compare.sv]
// ----------------------------------------------------------------------------
// ssfl_compare: parallel window compare
// Compares the newest pattern-length bytes of the window with the pattern,
// with optional A-Z case folding.
// ----------------------------------------------------------------------------
module ssfl_compare (
  input  ssfl_pkg::window_t                 window,
  input  logic [ssfl_pkg::PAT_W-1:0]        pattern,
  input  logic [ssfl_pkg::LEN_W-1:0]        len,
  input  logic                              fold,
  output logic                              match
);
  import ssfl_pkg::*;

  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  logic [MAX_PATTERN-1:0] lane_ok;

  // Pattern char k lines up with window entry len-1-k (oldest byte first)
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      logic [LEN_W-1:0]     diff;
      logic [BYTE_W-1:0]    p;
      logic [BYTE_W-1:0]    t;
      diff = len - LEN_W'(1) - LEN_W'(k);
      p    = pattern[k*BYTE_W +: BYTE_W];
      t    = window[diff[WIN_IDX_W-1:0]];
      if (fold) begin
        p = fold_lower(p);
        t = fold_lower(t);
      end
      lane_ok[k] = (LEN_W'(k) >= len) || (p == t);
    end
  end

  assign match = &lane_ok;

endmodule

[design/ssfl_result_buf.sv]
// ----------------------------------------------------------------------------
// ssfl_result_buf: output register with skid stage
// Holds results so the text side keeps flowing while the receiver stalls.
// ----------------------------------------------------------------------------
module ssfl_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ssfl_pkg::result_t push_data,
  output logic              space,
  output logic              valid,
  input  logic              ready,
  output ssfl_pkg::result_t data
);
  import ssfl_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop   = main_valid && ready;
  assign space = !skid_valid;
  assign valid = main_valid;
  assign data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

`ifndef SYNTH
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed while both entries are full");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (pop && skid_valid) |=> (main_valid && !skid_valid))
    else $error("skid entry not moved to the output register");
`endif

endmodule

[test/substring_search_first_last_unit_test.sv]
// ----------------------------------------------------------------------------
// substring_search_first_last_unit_test: self-checking bench for the search unit
// Streams texts through the byte channel and predicts each result with an
// in-bench model of the window compare. It covers the reset registers, every
// search mode, the case-fold edge characters, pattern length clamping,
// register changes between bytes, back-pressure and texts past the maximum
// length. Each result transfer is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module substring_search_first_last_unit_test;
  import ssfl_pkg::*;

  localparam int          RANDOM_BYTES = 1300;
  localparam int          HOLD_CYCLES  = 60;
  localparam logic [7:0]  CHAR_A       = "A";
  localparam logic [7:0]  CHAR_Z       = "Z";
  localparam logic [7:0]  CASE_GAP     = 8'd32;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ssfl_text_if   text_ch();
  ssfl_result_if result_ch();

  substring_search_first_last_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the registers as last written
  logic [PAT_W-1:0]  cfg_pattern = '0;
  logic [LEN_W-1:0]  cfg_len     = LEN_W'(1);
  logic [MODE_W-1:0] cfg_mode    = '0;

  // Mirror of the per-text search state
  window_t             recent      = '0;
  logic [POS_W-1:0]    text_pos    = '0;
  logic                have_match  = 1'b0;
  logic [INDEX_W-1:0]  kept_index  = '0;
  logic                overflowed  = 1'b0;

  result_t pending_results[$];
  logic [7:0] text_buf[$];

  // Idling controls shared between the test tasks and the two channel sides
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  int unsigned hold_request = 0;

  int unsigned texts_sent      = 0;
  int unsigned bytes_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake
  initial begin : watchdog
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CHAR_A && c <= CHAR_Z) ? c + CASE_GAP : c;
  endfunction

  // Length 0 acts as 1, anything past the window acts as the full window
  function automatic int unsigned eff_length(input logic [LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > MAX_PATTERN) return MAX_PATTERN;
    return 32'(l);
  endfunction

  // Advance the search state by one text byte; return 1 when the byte closes
  // a text, with the result that the block must give for it.
  function automatic bit search_step(input logic [7:0] b, input logic last,
                                     output result_t res);
    int unsigned len;
    logic        hit;
    logic [7:0]  p;
    logic [7:0]  t;
    len = eff_length(cfg_len);
    res = '0;
    if (text_pos >= MAX_TEXT) begin
      // Past the maximum: flag it, neither count nor search the byte
      overflowed = 1'b1;
    end else begin
      recent = {recent[MAX_PATTERN-2:0], b};
      if (int'(text_pos) + 1 >= len) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
          p = cfg_pattern[8*k +: 8];
          t = recent[len-1-k];
          if (cfg_mode[MODE_FOLD_BIT]) begin
            p = to_lower(p);
            t = to_lower(t);
          end
          if (p != t) hit = 1'b0;
        end
        if (hit && (cfg_mode[MODE_LAST_BIT] || !have_match)) begin
          have_match = 1'b1;
          kept_index = INDEX_W'(int'(text_pos) + 1 - len);
        end
      end
      text_pos = text_pos + 1'b1;
    end
    if (!last) return 1'b0;
    res.found       = have_match;
    res.match_index = have_match ? kept_index : '0;
    res.too_long    = overflowed;
    recent     = '0;
    text_pos   = '0;
    have_match = 1'b0;
    kept_index = '0;
    overflowed = 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Text channel
  // --------------------------------------------------------------------------
  // Offer one byte, after a random gap if sender_idle, and hold it until it transfers.
  // Valid stays high on return so that a following byte can go out back to back.
  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t     res;
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.last_byte <= last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    bytes_sent++;
    if (last) texts_sent++;
    if (search_step(b, last, res)) pending_results.push_back(res);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Drop valid, then wait until every predicted result has been taken and
  // let the block settle.
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  // Write all three registers on consecutive edges, only once the block is idle
  task automatic configure(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len,
                           input logic [MODE_W-1:0] mode);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_PATTERN_BYTES;
    cfg_data  <= pat;
    @(posedge clk);
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data  <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= REG_SEARCH_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_write   <= 1'b0;
    cfg_pattern = pat;
    cfg_len     = len;
    cfg_mode    = mode;
  endtask

  function automatic logic [PAT_W-1:0] pattern_of(input string s);
    logic [PAT_W-1:0] p;
    p = '0;
    for (int k = 0; k < s.len() && k < MAX_PATTERN; k++) p[8*k +: 8] = s[k];
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Result channel: random ready, check every transfer
  // --------------------------------------------------------------------------
  initial begin : result_check
    int unsigned gap;
    result_t     want;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = receiver_idle ? $urandom_range(0, 9) : 0;
      // A long hold-off asked for by a test overrides the random gap
      if (hold_request != 0) begin
        gap = hold_request;
        hold_request = 0;
      end
      if (gap != 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: found %0d match_index %0d too_long %0d",
                 $time, result_ch.found, result_ch.match_index, result_ch.too_long);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result_ch.found !== want.found) begin
          $display("%0t: found mismatch: expected %0d actual %0d",
                   $time, want.found, result_ch.found);
          mismatch_count++;
        end
        if (result_ch.match_index !== want.match_index) begin
          $display("%0t: match_index mismatch: expected %0d actual %0d",
                   $time, want.match_index, result_ch.match_index);
          mismatch_count++;
        end
        if (result_ch.too_long !== want.too_long) begin
          $display("%0t: too_long mismatch: expected %0d actual %0d",
                   $time, want.too_long, result_ch.too_long);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset registers: pattern of one zero byte, exact, first match
  task automatic test_reset_values();
    text_buf = '{8'h00};
    send_text();
    text_buf = '{"q", 8'h00, 8'h00};
    send_text();
  endtask

  // Same text under all four modes: exact hit at 2, folded hits at 0 and 2
  task automatic test_search_modes();
    for (int m = 0; m < 4; m++) begin
      configure(pattern_of("Ab"), 4'd2, MODE_W'(m));
      send_string("aBAb");
    end
  endtask

  // Fold touches A-Z only: '`' and '{' must not meet '@' and '['
  task automatic test_fold_edges();
    configure(pattern_of("@["), 4'd2, 2'b11);
    send_string("`{@[");
  endtask

  // Length clamping, extreme byte values and a text shorter than the pattern
  task automatic test_length_limits();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 2'b00);
    text_buf = '{8'hFF};
    send_text();
    configure(64'h00FF_7F80_0102_41FE, 4'd15, 2'b01);
    text_buf = '{8'hFE, 8'h61, 8'h02, 8'h01, 8'h80, 8'h7F, 8'hFF, 8'h00};
    send_text();
    // Zeroed window must not stand in for bytes that never came
    configure(64'h0, 4'd4, 2'b00);
    text_buf = '{8'h00, 8'h00, 8'h00};
    send_text();
  endtask

  // Registers changed between two bytes of one text; window keeps raw bytes
  task automatic test_midtext_change();
    configure(pattern_of("ab"), 4'd2, 2'b00);
    send_byte("x", 1'b0);
    send_byte("a", 1'b0);
    configure(pattern_of("AC"), 4'd2, 2'b01);
    send_byte("c", 1'b1);
  endtask

  // Receiver stalls for a long stretch while single-byte texts keep coming,
  // so both result entries fill and the text channel must back off.
  task automatic test_backpressure();
    configure(pattern_of("k"), 4'd1, 2'b00);
    sender_idle  = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) send_byte((i % 2) ? "k" : "j", 1'b1);
    drain_results();
    sender_idle = 1'b1;
  endtask

  // Pattern characters lean on a few letters and the fold edges so that
  // random texts hit often.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: begin
        c = 8'h61 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) c = c - CASE_GAP;
      end
      5: begin
        case ($urandom_range(0, 3))
          0: c = 8'h40;
          1: c = 8'h5B;
          2: c = 8'h60;
          default: c = 8'h7B;
        endcase
      end
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  task automatic random_config();
    logic [PAT_W-1:0]  pat;
    logic [LEN_W-1:0]  len;
    logic [MODE_W-1:0] mode;
    pat = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0)
      for (int k = 0; k < MAX_PATTERN; k++) pat[8*k +: 8] = pick_char();
    if ($urandom_range(0, 9) == 0)
      len = $urandom_range(0, 1) ? 4'd0 : LEN_W'($urandom_range(9, 15));
    else
      len = LEN_W'($urandom_range(1, 8));
    mode = MODE_W'($urandom_range(0, 3));
    configure(pat, len, mode);
  endtask

  // Mostly texts built from pattern and picked characters with the pattern
  // planted one to three times (case flipped at random under fold); the rest raw noise.
  task automatic random_text();
    int unsigned len;
    int unsigned tlen;
    int unsigned pos;
    int unsigned shape;
    logic [7:0]  c;
    len   = eff_length(cfg_len);
    tlen  = $urandom_range(1, 24);
    shape = $urandom_range(0, 9);
    text_buf.delete();
    for (int i = 0; i < tlen; i++) begin
      if (shape >= 7)
        c = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 1)) begin
        pos = $urandom_range(0, len - 1);
        c   = cfg_pattern[8*pos +: 8];
      end else
        c = pick_char();
      text_buf.push_back(c);
    end
    if (shape < 7 && tlen >= len) begin
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(0, tlen - len);
        for (int k = 0; k < len; k++) begin
          c = cfg_pattern[8*k +: 8];
          // Flip only letters: the upper-case form must fold to something else
          if (cfg_mode[MODE_FOLD_BIT] && to_lower(c & ~CASE_GAP) != (c & ~CASE_GAP)
              && $urandom_range(0, 1))
            c = c ^ CASE_GAP;
          text_buf[pos+k] = c;
        end
      end
    end
    send_text();
  endtask

  task automatic test_random_texts();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) random_config();
      // Mostly idle on both sides, with stretches at full rate
      sender_idle   = $urandom_range(0, 4) != 0;
      receiver_idle = $urandom_range(0, 4) != 0;
      random_text();
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Texts at and past the maximum length, pattern planted so that it ends
  // on the last counted byte and once more after the count has saturated.
  task automatic send_long_text(input int unsigned total);
    int unsigned planted;
    logic [7:0]  c;
    planted = MAX_TEXT - 4;
    for (int unsigned i = 0; i < total; i++) begin
      c = 8'($urandom_range(0, 8'h3F));
      if (i >= planted && i < planted + 4)
        c = cfg_pattern[8*(i-planted) +: 8];
      else if (total > MAX_TEXT + 4 && i > MAX_TEXT && i <= MAX_TEXT + 4)
        c = cfg_pattern[8*(i-MAX_TEXT-1) +: 8];
      send_byte(c, i == total - 1);
    end
  endtask

  task automatic test_text_too_long();
    configure(pattern_of("LONG"), 4'd4, 2'b10);
    sender_idle = 1'b0;
    send_long_text(MAX_TEXT);
    send_long_text(MAX_TEXT + 8);
    sender_idle = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_PATTERN_BYTES;
    cfg_data          <= '0;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= '0;
    text_ch.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_search_modes();
    test_fold_edges();
    test_length_limits();
    test_midtext_change();
    test_backpressure();
    test_random_texts();
    test_text_too_long();

    // Wait out the last results
    drain_results();
    repeat (10) @(posedge clk);

    $display("Searched %0d texts (%0d bytes) across all modes and pattern lengths,",
             texts_sent, bytes_sent);
    $display("including overflow past %0d bytes; %0d results checked, %0d mismatches.",
             MAX_TEXT, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
